@@ hdl/smooth_escape_palette_color_core_macros.svh @@
// Assertion macros shared by the smooth escape palette color core.
`ifndef SMOOTH_ESCAPE_PALETTE_COLOR_CORE_MACROS_SVH
`define SMOOTH_ESCAPE_PALETTE_COLOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SEPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sepc assertion failed");

// Next-cycle implication, checked outside reset.
`define SEPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sepc assertion failed");

`endif

@@ hdl/sepc_pkg.sv @@
// Types, constants and palette functions of the smooth escape palette color core.
package sepc_pkg;

  localparam int PALETTE_DEPTH_DEF = 512;
  localparam int LOG_FRAC = 16;
  localparam logic [15:0] MAX_ITER_RESET = 16'd256;
  localparam logic [32:0] NEG_LOG2_LN2_Q16 = 33'd34653;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] STEP_Q30 = 64'd214748365;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic        invalid;
    logic [3:0]  ip;
    logic [15:0] iter;
  } log1_side_t;

  typedef struct packed {
    logic        invalid;
    logic        lq_zero;
    logic [4:0]  p2;
    logic [15:0] iter;
  } log2_side_t;

  typedef struct packed {
    logic invalid;
    logic lq_zero;
    logic ovf;
  } div_side_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
    logic       invalid;
  } out_t;

  function automatic logic [5:0] top_bit64(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [4:0] top_bit20(logic [19:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 1; i < 20; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [7:0] channel_of(logic [63:0] a);
    logic [63:0] r;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] prod;
    logic neg;
    r = a % TWO_PI_Q30;
    neg = 1'b0;
    if (r >= PI_Q30) begin
      neg = 1'b1;
      r = r - PI_Q30;
    end
    if (r > HALF_PI_Q30) r = PI_Q30 - r;
    x2 = (r * r) >> 30;
    term = r;
    s = r;
    for (int k = 1; k <= 8; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1: term = prod / 64'd6;
        2: term = prod / 64'd20;
        3: term = prod / 64'd42;
        4: term = prod / 64'd72;
        5: term = prod / 64'd110;
        6: term = prod / 64'd156;
        7: term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
      if (k % 2 == 1) s = (s >= term) ? s - term : 64'd0;
      else s = s + term;
    end
    if (s > ONE_Q30) s = ONE_Q30;
    v = neg ? ONE_Q30 - s : ONE_Q30 + s;
    v = (v * 64'd255) >> 31;
    return v[7:0];
  endfunction

  function automatic logic [23:0] palette_entry(logic [31:0] i);
    logic [63:0] a;
    a = {32'd0, i} * STEP_Q30;
    return {channel_of(a), channel_of(a + 64'd2 * ONE_Q30), channel_of(a + 64'd4 * ONE_Q30)};
  endfunction

endpackage

@@ hdl/smooth_escape_palette_color_core.sv @@
// Top level of the smooth escape palette color core.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   z_real, z_imag, iteration_count
//  out      out_valid / out_ready red, green, blue, index_clamped, invalid_norm
//  cfg      cfg_valid / cfg_ready cfg_data (max_iterations)
//
// One beat is accepted every cycle while no beat is parked in the skid register.
// The two 16-stage squaring pipelines of the logarithms make up most of the depth.
// Reset clears all valid bits and sets max_iterations to 256.
// A stalled output parks one beat in a skid register; the pipeline then holds.
`include "smooth_escape_palette_color_core_macros.svh"

module smooth_escape_palette_color_core #(
  parameter int PALETTE_DEPTH = sepc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] z_real,
  input  logic signed [31:0] z_imag,
  input  logic [15:0]        iteration_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               index_clamped,
  output logic               invalid_norm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int IDXW = $clog2(PALETTE_DEPTH);
  localparam int NW = 33;
  localparam int PW = NW + IDXW;
  localparam int QW = PW - 16;
  localparam logic [IDXW-1:0] TOP = IDXW'(PALETTE_DEPTH - 1);

  logic en;
  logic [15:0] lim;
  logic skid_valid;
  sepc_pkg::out_t out_data, skid_data, p12;

  assign en = !skid_valid;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= sepc_pkg::MAX_ITER_RESET;
    end else if (cfg_valid) begin
      lim <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic [31:0] mr1, mi1;
  logic [15:0] it1, it2, it3, it4;
  logic [63:0] sqr2, sqi2, mag3, mag4;
  logic [5:0] p4;
  logic inv4;
  logic [31:0] m5, m7;
  sepc_pkg::log1_side_t s5, ls1;
  sepc_pkg::log2_side_t s7, ls2;
  logic lv1, lv2;
  logic [15:0] lf1, lf2;
  logic [19:0] lq6;
  logic [4:0] p6;
  logic inv6, zero6;
  logic [15:0] it6;
  logic [NW-1:0] n8;
  logic [PW-1:0] prod9;
  logic inv8, zero8, inv9, zero9;
  logic [QW-1:0] q10;
  sepc_pkg::div_side_t s10, ds;
  logic dv;
  logic [IDXW-1:0] quo, addr11;
  logic clamp11, inv11, clamp12, inv12;
  logic [23:0] rgb12;
  logic [31:0] ur, ui;
  logic [16:0] hi8;

  assign ur = z_real;
  assign ui = z_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= lv1;
      v7 <= v6;
      v8 <= lv2;
      v9 <= v8;
      v10 <= v9;
      v11 <= dv;
      v12 <= v11;
    end
  end

  always_comb begin
    hi8 = 17'(ls2.iter) + 17'd22 - 17'(ls2.p2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mr1 <= ur[31] ? ~ur + 32'd1 : ur;
      mi1 <= ui[31] ? ~ui + 32'd1 : ui;
      it1 <= iteration_count;
      sqr2 <= {32'd0, mr1} * {32'd0, mr1};
      sqi2 <= {32'd0, mi1} * {32'd0, mi1};
      it2 <= it1;
      mag3 <= sqr2 + sqi2;
      it3 <= it2;
      p4 <= sepc_pkg::top_bit64(mag3);
      mag4 <= mag3;
      inv4 <= mag3 <= 64'h0001_0000_0000_0000;
      it4 <= it3;
      m5 <= 32'(mag4 >> (p4 - 6'd31));
      s5.invalid <= inv4;
      s5.ip <= 4'(p4 - 6'd48);
      s5.iter <= it4;
      lq6 <= {ls1.ip, lf1};
      p6 <= sepc_pkg::top_bit20({ls1.ip, lf1});
      inv6 <= ls1.invalid;
      zero6 <= {ls1.ip, lf1} == 20'd0;
      it6 <= ls1.iter;
      m7 <= {12'd0, lq6} << (5'd31 - p6);
      s7.invalid <= inv6;
      s7.lq_zero <= zero6;
      s7.p2 <= p6;
      s7.iter <= it6;
      n8 <= {hi8, 16'd0} + sepc_pkg::NEG_LOG2_LN2_Q16 - NW'(lf2);
      inv8 <= ls2.invalid;
      zero8 <= ls2.lq_zero;
      prod9 <= PW'(n8) * PW'(TOP);
      inv9 <= inv8;
      zero9 <= zero8;
      q10 <= prod9[PW-1:16];
      s10.ovf <= prod9[PW-1:16] >= QW'(lim) * QW'(PALETTE_DEPTH);
      s10.invalid <= inv9;
      s10.lq_zero <= zero9;
      addr11 <= ds.invalid ? '0 : ((ds.lq_zero || ds.ovf) ? TOP : quo);
      clamp11 <= !ds.invalid && (ds.lq_zero || ds.ovf);
      inv11 <= ds.invalid;
      clamp12 <= clamp11;
      inv12 <= inv11;
    end
  end

  sepc_log2 #(.side_t(sepc_pkg::log1_side_t)) u_log_mag (
    .clk, .rst, .en,
    .in_valid(v5), .in_mant(m5), .in_side(s5),
    .out_valid(lv1), .out_frac(lf1), .out_side(ls1)
  );

  sepc_log2 #(.side_t(sepc_pkg::log2_side_t)) u_log_lq (
    .clk, .rst, .en,
    .in_valid(v7), .in_mant(m7), .in_side(s7),
    .out_valid(lv2), .out_frac(lf2), .out_side(ls2)
  );

  sepc_div #(.IdxW(IDXW), .QW(QW), .side_t(sepc_pkg::div_side_t)) u_div (
    .clk, .rst, .en, .lim,
    .in_valid(v10), .in_q(q10), .in_side(s10),
    .out_valid(dv), .out_quo(quo), .out_side(ds)
  );

  sepc_rom #(.Depth(PALETTE_DEPTH)) u_rom (
    .clk, .en, .addr(addr11), .data(rgb12)
  );

  always_comb begin
    p12.red = rgb12[23:16];
    p12.green = rgb12[15:8];
    p12.blue = rgb12[7:0];
    p12.clamped = clamp12;
    p12.invalid = inv12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (v12) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
        out_data <= p12;
      end else begin
        skid_valid <= 1'b1;
        skid_data <= p12;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign red = out_data.red;
  assign green = out_data.green;
  assign blue = out_data.blue;
  assign index_clamped = out_data.clamped;
  assign invalid_norm = out_data.invalid;

  `SEPC_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `SEPC_ASSERT_NOW(a_invalid_not_clamped, out_valid && invalid_norm, !index_clamped)
  `SEPC_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid)

endmodule

@@ hdl/sepc_log2.sv @@
// Pipelined fractional log2: one squaring step per stage on a normalized mantissa.
module sepc_log2 #(
  parameter type side_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_mant,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [sepc_pkg::LOG_FRAC-1:0] out_frac,
  output side_t       out_side
);

  localparam int N = sepc_pkg::LOG_FRAC;

  logic                v_p [N+1];
  logic [31:0]         m_p [N+1];
  logic [N-1:0]        f_p [N+1];
  side_t               s_p [N+1];

  assign v_p[0] = in_valid;
  assign m_p[0] = in_mant;
  assign f_p[0] = '0;
  assign s_p[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] m_next;

    always_comb begin
      sq = {32'd0, m_p[k]} * {32'd0, m_p[k]};
      t = sq[63:31];
      m_next = t[32] ? t[32:1] : t[31:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else if (en) begin
        v_p[k+1] <= v_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_p[k+1] <= m_next;
        f_p[k+1] <= {f_p[k][N-2:0], t[32]};
        s_p[k+1] <= s_p[k];
      end
    end
  end

  assign out_valid = v_p[N];
  assign out_frac = f_p[N];
  assign out_side = s_p[N];

endmodule

@@ hdl/sepc_div.sv @@
// Pipelined restoring divider that yields the palette index, one quotient bit per stage.
module sepc_div #(
  parameter int IdxW = 9,
  parameter int QW = 26,
  parameter type side_t = logic
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [15:0]     lim,
  input  logic            in_valid,
  input  logic [QW-1:0]   in_q,
  input  side_t           in_side,
  output logic            out_valid,
  output logic [IdxW-1:0] out_quo,
  output side_t           out_side
);

  logic            v_p [IdxW+1];
  logic [QW-1:0]   r_p [IdxW+1];
  logic [IdxW-1:0] q_p [IdxW+1];
  side_t           s_p [IdxW+1];

  assign v_p[0] = in_valid;
  assign r_p[0] = in_q;
  assign q_p[0] = '0;
  assign s_p[0] = in_side;

  for (genvar k = 0; k < IdxW; k++) begin : g_stage
    logic [QW-1:0] dv;
    logic          take;

    always_comb begin
      dv = QW'(lim) << (IdxW - 1 - k);
      take = r_p[k] >= dv;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else if (en) begin
        v_p[k+1] <= v_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_p[k+1] <= take ? r_p[k] - dv : r_p[k];
        q_p[k+1] <= {q_p[k][IdxW-2:0], take};
        s_p[k+1] <= s_p[k];
      end
    end
  end

  assign out_valid = v_p[IdxW];
  assign out_quo = q_p[IdxW];
  assign out_side = s_p[IdxW];

endmodule

@@ hdl/sepc_rom.sv @@
// Sinusoidal palette ROM with a registered read port.
module sepc_rom #(
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(Depth)-1:0] addr,
  output logic [23:0]              data
);

  typedef logic [23:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < Depth; i++) begin
      t[i] = sepc_pkg::palette_entry(32'(i));
    end
    return t;
  endfunction

  localparam rom_t RomData = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= RomData[addr];
    end
  end

endmodule
